FILE: rtl/lpr_pkg.sv
// Shared types and constants for the line pixel rasterizer.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package lpr_pkg;

   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 64;

   localparam int COLOR_W = 16;
   localparam int COORD_W = 8;
   localparam int PIXEL_W = 6;
   localparam int DELTA_W = COORD_W + 1;
   localparam int ERR_W   = COORD_W + 3;

   localparam logic [COORD_W-1:0] SCR_W = COORD_W'(SCREEN_WIDTH);
   localparam logic [COORD_W-1:0] SCR_H = COORD_W'(SCREEN_HEIGHT);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;

   typedef struct packed {
      logic [COLOR_W-1:0]       color;
      logic [COORD_W-1:0]       x0;
      logic [COORD_W-1:0]       y0;
      logic                     x_major;
      logic                     x_neg;
      logic                     y_neg;
      logic [DELTA_W-1:0]       two_minor;
      logic [DELTA_W-1:0]       two_major;
      logic signed [ERR_W-1:0]  err_init;
      logic [COORD_W-1:0]       count;
   } cmd_type;

endpackage

`default_nettype wire

FILE: rtl/lpr_if.sv
// Valid/ready channel interfaces for line commands and for pixels.
// Depends on lpr_pkg for field widths.
`default_nettype none

interface lpr_req_if;
   logic                        valid;
   logic                        ready;
   logic [lpr_pkg::COLOR_W-1:0] color;
   logic [lpr_pkg::COORD_W-1:0] start_x;
   logic [lpr_pkg::COORD_W-1:0] start_y;
   logic [lpr_pkg::COORD_W-1:0] end_x;
   logic [lpr_pkg::COORD_W-1:0] end_y;
   logic                        landscape;

   modport source (output valid, color, start_x, start_y, end_x, end_y, landscape,
                   input ready);
   modport sink (input valid, color, start_x, start_y, end_x, end_y, landscape,
                 output ready);
endinterface

interface lpr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lpr_pkg::PIXEL_W-1:0] pixel_x;
   logic [lpr_pkg::PIXEL_W-1:0] pixel_y;
   logic [lpr_pkg::COLOR_W-1:0] pixel_color;
   logic                        last;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
   modport sink (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/lpr_front.sv
// Front end: accepts a line command and works out the stepping set-up.
// Depends on lpr_pkg and lpr_req_if.
`default_nettype none

module lpr_front (
   lpr_req_if.sink          req_ch,
   input  logic             q_full,
   output logic             q_push,
   output lpr_pkg::cmd_type q_data
);

   logic [lpr_pkg::COORD_W-1:0] x0, y0, x1, y1;
   logic [lpr_pkg::COORD_W-1:0] adx, ady, major, minor;
   logic                        x_neg, y_neg, x_major;

   always_comb begin
      if (req_ch.landscape) begin
         x0 = req_ch.start_x;
         y0 = req_ch.start_y;
         x1 = req_ch.end_x;
         y1 = req_ch.end_y;
      end else begin
         x0 = req_ch.start_y;
         y0 = req_ch.start_x;
         x1 = req_ch.end_y;
         y1 = req_ch.end_x;
      end
      x_neg   = x1 < x0;
      y_neg   = y1 < y0;
      adx     = x_neg ? x0 - x1 : x1 - x0;
      ady     = y_neg ? y0 - y1 : y1 - y0;
      x_major = adx > ady;
      major   = x_major ? adx : ady;
      minor   = x_major ? ady : adx;

      q_data.color     = req_ch.color;
      q_data.x0        = x0;
      q_data.y0        = y0;
      q_data.x_major   = x_major;
      q_data.x_neg     = x_neg;
      q_data.y_neg     = y_neg;
      q_data.two_minor = {minor, 1'b0};
      q_data.two_major = {major, 1'b0};
      q_data.err_init  = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
      q_data.count     = major;
   end

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;

endmodule

`default_nettype wire

FILE: rtl/lpr_queue.sv
// Short command queue between the front end and the stepping engine.
// Depends on lpr_pkg for the command type and depth.
`default_nettype none

module lpr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lpr_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output lpr_pkg::cmd_type pop_data
);

   lpr_pkg::cmd_type              entry_ff [lpr_pkg::QUEUE_DEPTH];
   logic [lpr_pkg::QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [lpr_pkg::QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [lpr_pkg::QUEUE_AW:0]    fill_ff, fill_in;
   logic                          do_push, do_pop;

   assign full      = fill_ff == (lpr_pkg::QUEUE_AW + 1)'(lpr_pkg::QUEUE_DEPTH);
   assign not_empty = fill_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/lpr_back.sv
// Stepping engine: walks the line one point a cycle when not stalled, drops off-screen points,
// holds back one visible pixel to mark the last one. Depends on lpr_pkg and lpr_rsp_if.
`default_nettype none

module lpr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_not_empty,
   input  lpr_pkg::cmd_type q_data,
   output logic             q_pop,
   lpr_rsp_if.source        rsp_ch
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]                         state_ff, state_in;
   logic [lpr_pkg::COLOR_W-1:0]        color_ff, color_in;
   logic                               x_major_ff, x_major_in;
   logic                               x_neg_ff, x_neg_in;
   logic                               y_neg_ff, y_neg_in;
   logic [lpr_pkg::DELTA_W-1:0]        two_minor_ff, two_minor_in;
   logic [lpr_pkg::DELTA_W-1:0]        two_major_ff, two_major_in;
   logic [lpr_pkg::COORD_W-1:0]        x_ff, x_in, y_ff, y_in;
   logic signed [lpr_pkg::ERR_W-1:0]   err_ff, err_in;
   logic [lpr_pkg::COORD_W-1:0]        cnt_ff, cnt_in;
   logic                               hold_valid_ff, hold_valid_in;
   logic [lpr_pkg::PIXEL_W-1:0]        hold_x_ff, hold_x_in, hold_y_ff, hold_y_in;
   logic                               out_valid_ff, out_valid_in;
   logic [lpr_pkg::PIXEL_W-1:0]        out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [lpr_pkg::COLOR_W-1:0]        out_color_ff, out_color_in;
   logic                               out_last_ff, out_last_in;

   logic                               out_free, visible, stall, err_ge0, step_x, step_y;
   logic signed [lpr_pkg::ERR_W-1:0]   err_step;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign visible  = (x_ff < lpr_pkg::SCR_W) && (y_ff < lpr_pkg::SCR_H);
   assign stall    = visible && hold_valid_ff && !out_free;
   assign err_ge0  = !err_ff[lpr_pkg::ERR_W-1];
   assign step_x   = x_major_ff || err_ge0;
   assign step_y   = !x_major_ff || err_ge0;
   assign err_step = err_ff + $signed({2'b00, two_minor_ff})
                     - (err_ge0 ? $signed({2'b00, two_major_ff}) : '0);
   assign q_pop    = (state_ff == ST_IDLE) && q_not_empty;

   always_comb begin
      state_in      = state_ff;
      color_in      = color_ff;
      x_major_in    = x_major_ff;
      x_neg_in      = x_neg_ff;
      y_neg_in      = y_neg_ff;
      two_minor_in  = two_minor_ff;
      two_major_in  = two_major_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      err_in        = err_ff;
      cnt_in        = cnt_ff;
      hold_valid_in = hold_valid_ff;
      hold_x_in     = hold_x_ff;
      hold_y_in     = hold_y_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_color_in  = out_color_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               color_in     = q_data.color;
               x_major_in   = q_data.x_major;
               x_neg_in     = q_data.x_neg;
               y_neg_in     = q_data.y_neg;
               two_minor_in = q_data.two_minor;
               two_major_in = q_data.two_major;
               x_in         = q_data.x0;
               y_in         = q_data.y0;
               err_in       = q_data.err_init;
               cnt_in       = q_data.count;
               state_in     = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!stall) begin
               if (visible) begin
                  if (hold_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_x_in     = hold_x_ff;
                     out_y_in     = hold_y_ff;
                     out_color_in = color_ff;
                     out_last_in  = 1'b0;
                  end
                  hold_valid_in = 1'b1;
                  hold_x_in     = x_ff[lpr_pkg::PIXEL_W-1:0];
                  hold_y_in     = y_ff[lpr_pkg::PIXEL_W-1:0];
               end
               if (cnt_ff == '0) begin
                  state_in = ST_FLUSH;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
                  err_in = err_step;
                  if (step_x) begin
                     x_in = x_neg_ff ? x_ff - 1'b1 : x_ff + 1'b1;
                  end
                  if (step_y) begin
                     y_in = y_neg_ff ? y_ff - 1'b1 : y_ff + 1'b1;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_x_in      = hold_x_ff;
               out_y_in      = hold_y_ff;
               out_color_in  = color_ff;
               out_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff     <= color_in;
      x_major_ff   <= x_major_in;
      x_neg_ff     <= x_neg_in;
      y_neg_ff     <= y_neg_in;
      two_minor_ff <= two_minor_in;
      two_major_ff <= two_major_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      err_ff       <= err_in;
      cnt_ff       <= cnt_in;
      hold_x_ff    <= hold_x_in;
      hold_y_ff    <= hold_y_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.pixel_x     = out_x_ff;
   assign rsp_ch.pixel_y     = out_y_ff;
   assign rsp_ch.pixel_color = out_color_ff;
   assign rsp_ch.last        = out_last_ff;

endmodule

`default_nettype wire

FILE: rtl/line_pixel_rasterizer_top.sv
// Top level of the line pixel rasterizer: front end, command queue and stepping engine.
// Depends on lpr_pkg, lpr_if, lpr_front, lpr_queue and lpr_back.
//
// Each line command transfer yields the visible pixels of a Bresenham line from start to
// end, both ends included, in drawing order, with last set on the final visible one; a
// line wholly off the screen yields nothing. The stepping engine visits one point of the
// major axis per cycle when the pixel side keeps up. A two-entry queue lets further
// commands be taken while a line is being drawn.
`default_nettype none

module line_pixel_rasterizer_top (
   input  logic       clock,
   input  logic       reset,
   lpr_req_if.sink    req_ch,
   lpr_rsp_if.source  rsp_ch
);

   lpr_pkg::cmd_type push_data, pop_data;
   logic             push, full, pop, not_empty;

   lpr_front u_front (
      .req_ch (req_ch),
      .q_full (full),
      .q_push (push),
      .q_data (push_data)
   );

   lpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   lpr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (not_empty),
      .q_data      (pop_data),
      .q_pop       (pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for line_pixel_rasterizer_top: line commands in, checked pixels out.
// Depends on lpr_pkg, the lpr_req_if and lpr_rsp_if channel interfaces and the block's RTL.
// Expected pixels come from a Bresenham walk computed here for every accepted command.

module testbench;

   typedef struct {
      logic [lpr_pkg::COLOR_W-1:0] color;
      logic [lpr_pkg::COORD_W-1:0] start_x;
      logic [lpr_pkg::COORD_W-1:0] start_y;
      logic [lpr_pkg::COORD_W-1:0] end_x;
      logic [lpr_pkg::COORD_W-1:0] end_y;
      logic                        landscape;
      bit                          drain_first;
   } line_cmd_type;

   typedef struct packed {
      logic [lpr_pkg::PIXEL_W-1:0] x;
      logic [lpr_pkg::PIXEL_W-1:0] y;
      logic [lpr_pkg::COLOR_W-1:0] color;
      logic                        last;
   } screen_pixel_type;

   localparam int RANDOM_LINES = 360;
   localparam int MAX_VISIBLE  = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lpr_req_if req_ch ();
   lpr_rsp_if rsp_ch ();

   line_pixel_rasterizer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   line_cmd_type     pending_lines[$];
   screen_pixel_type expected_pixels[$];
   line_cmd_type     line_on_bus;
   int               lines_taken = 0;
   int               errors = 0;
   int               visible_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_phase();
      if (lines_taken < 120) begin
         return 0;
      end else if (lines_taken < 240) begin
         return 1;
      end
      return 2;
   endfunction

   function automatic bit sender_idle();
      int pct;
      pct = (idle_phase() == 0) ? 13 : (idle_phase() == 1) ? 48 : 0;
      return $urandom_range(99) < pct;
   endfunction

   function automatic bit receiver_idle();
      int pct;
      pct = (idle_phase() == 0) ? 48 : (idle_phase() == 1) ? 13 : 0;
      return $urandom_range(99) < pct;
   endfunction

   function automatic void add_visible(input int x, input int y,
                                       input logic [lpr_pkg::COLOR_W-1:0] color);
      screen_pixel_type p;
      if (x < 0 || y < 0 || x >= lpr_pkg::SCREEN_WIDTH || y >= lpr_pkg::SCREEN_HEIGHT) begin
         return;
      end
      if (visible_count >= MAX_VISIBLE) begin
         return;
      end
      p.x = x[lpr_pkg::PIXEL_W-1:0];
      p.y = y[lpr_pkg::PIXEL_W-1:0];
      p.color = color;
      p.last = 1'b0;
      expected_pixels.push_back(p);
      visible_count++;
   endfunction

   // Walks the line exactly as the block should and queues its visible pixels.
   function automatic void predict_line(input line_cmd_type c);
      int x0, y0, x1, y1, dx, dy, sx, sy, err, x, y;
      if (c.landscape) begin
         x0 = int'(c.start_x); y0 = int'(c.start_y);
         x1 = int'(c.end_x);   y1 = int'(c.end_y);
      end else begin
         x0 = int'(c.start_y); y0 = int'(c.start_x);
         x1 = int'(c.end_y);   y1 = int'(c.end_x);
      end
      visible_count = 0;
      dx = x1 - x0;
      dy = y1 - y0;
      sx = (dx < 0) ? -1 : 1;
      sy = (dy < 0) ? -1 : 1;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      x = x0;
      y = y0;
      add_visible(x, y, c.color);
      if (dx > dy) begin
         err = 2 * dy - dx;
         for (int i = 0; i < dx; i++) begin
            if (err >= 0) begin
               y += sy;
               err -= 2 * dx;
            end
            x += sx;
            err += 2 * dy;
            add_visible(x, y, c.color);
         end
      end else begin
         err = 2 * dx - dy;
         for (int i = 0; i < dy; i++) begin
            if (err >= 0) begin
               x += sx;
               err -= 2 * dy;
            end
            y += sy;
            err += 2 * dx;
            add_visible(x, y, c.color);
         end
      end
      if (visible_count > 0) begin
         expected_pixels[expected_pixels.size() - 1].last = 1'b1;
      end
   endfunction

   task automatic add_line(input logic [15:0] color, input int sx, input int sy,
                           input int ex, input int ey, input bit landscape,
                           input bit drain_first = 1'b0);
      line_cmd_type c;
      c.color = color;
      c.start_x = sx[7:0];
      c.start_y = sy[7:0];
      c.end_x = ex[7:0];
      c.end_y = ey[7:0];
      c.landscape = landscape;
      c.drain_first = drain_first;
      pending_lines.push_back(c);
   endtask

   task automatic add_random_line(input bit drain_first);
      int r, span, sx, sy, ex, ey;
      r = $urandom_range(99);
      span = (r < 70) ? 63 : (r < 85) ? 95 : 255;
      sx = $urandom_range(span);
      sy = $urandom_range(span);
      ex = $urandom_range(span);
      ey = $urandom_range(span);
      r = $urandom_range(99);
      if (r < 6) begin
         ey = sy;
      end else if (r < 12) begin
         ex = sx;
      end else if (r < 15) begin
         ex = sx;
         ey = sy;
      end
      add_line(16'($urandom), sx, sy, ex, ey, 1'($urandom_range(1)), drain_first);
   endtask

   // Command driver: a new transfer is offered only once the previous one has gone.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_line(line_on_bus);
            lines_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_lines.size() > 0 && !sender_idle()
                && !(pending_lines[0].drain_first && expected_pixels.size() > 0)) begin
               line_on_bus = pending_lines.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.color     <= line_on_bus.color;
               req_ch.start_x   <= line_on_bus.start_x;
               req_ch.start_y   <= line_on_bus.start_y;
               req_ch.end_x     <= line_on_bus.end_x;
               req_ch.end_y     <= line_on_bus.end_y;
               req_ch.landscape <= line_on_bus.landscape;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Pixel monitor: every transfer is checked against the oldest expected pixel.
   always @(posedge clock) begin
      screen_pixel_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel x=%0d y=%0d", rsp_ch.pixel_x, rsp_ch.pixel_y);
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_ch.pixel_x !== want.x) begin
                  $error("pixel_x expected %0d actual %0d", want.x, rsp_ch.pixel_x);
                  errors++;
               end
               if (rsp_ch.pixel_y !== want.y) begin
                  $error("pixel_y expected %0d actual %0d", want.y, rsp_ch.pixel_y);
                  errors++;
               end
               if (rsp_ch.pixel_color !== want.color) begin
                  $error("pixel_color expected %h actual %h", want.color,
                         rsp_ch.pixel_color);
                  errors++;
               end
               if (rsp_ch.last !== want.last) begin
                  $error("last expected %0d actual %0d", want.last, rsp_ch.last);
                  errors++;
               end
            end
         end
         rsp_ch.ready <= !receiver_idle();
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.color = '0;
      req_ch.start_x = '0;
      req_ch.start_y = '0;
      req_ch.end_x = '0;
      req_ch.end_y = '0;
      req_ch.landscape = 1'b0;
      rsp_ch.ready = 1'b0;

      add_line(16'h0000, 5, 5, 5, 5, 1'b1);
      add_line(16'hFFFF, 200, 200, 200, 200, 1'b1);
      add_line(16'h1234, 3, 10, 40, 10, 1'b1);
      add_line(16'h8001, 63, 20, 0, 20, 1'b1);
      add_line(16'h5A5A, 7, 0, 7, 63, 1'b1);
      add_line(16'hA5A5, 30, 63, 30, 0, 1'b1);
      add_line(16'h00FF, 0, 0, 63, 63, 1'b1);
      add_line(16'hFF00, 63, 0, 0, 63, 1'b1);
      add_line(16'h0F0F, 0, 0, 255, 255, 1'b1);
      add_line(16'hF0F0, 255, 0, 0, 255, 1'b0);
      add_line(16'h7FFF, 255, 255, 0, 0, 1'b1);
      add_line(16'h4321, 0, 255, 255, 0, 1'b0);
      add_line(16'h1111, 2, 50, 10, 3, 1'b0);
      add_line(16'h2222, 60, 1, 4, 12, 1'b1);
      add_line(16'h3333, 10, 2, 13, 61, 1'b1);
      add_line(16'h4444, 100, 10, 0, 20, 1'b1);
      add_line(16'h5555, 10, 100, 20, 0, 1'b0);
      add_line(16'h6666, 70, 0, 200, 0, 1'b1);
      add_line(16'h7777, 0, 64, 63, 255, 1'b1);
      add_line(16'h8888, 64, 64, 255, 255, 1'b0);
      add_line(16'h9999, 20, 40, 40, 20, 1'b0);
      add_line(16'hCCCC, 0, 0, 128, 1, 1'b1);
      for (int i = 0; i < RANDOM_LINES; i++) begin
         add_random_line(i == 0 || i == 150 || i == 300);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_lines.size() > 0 || req_ch.valid) @(posedge clock);
      while (expected_pixels.size() > 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (errors == 0) begin
         $display("PASS line_pixel_rasterizer_top");
      end else begin
         $display("FAIL line_pixel_rasterizer_top");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("FAIL line_pixel_rasterizer_top");
      $finish;
   end

endmodule
